@@ design/chroma_key_alpha_overlay_defines.svh @@
// ---------------------------------------------------------------------------
// Chroma key alpha overlay assertion macros
// Shared assertion wrappers, clocked on clk and disabled while arst_n is low.
// ---------------------------------------------------------------------------
`ifndef CHROMA_KEY_ALPHA_OVERLAY_DEFINES_SVH
`define CHROMA_KEY_ALPHA_OVERLAY_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define CKAO_ASSERT_IMPL(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication.
`define CKAO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define CKAO_ASSERT_IMPL(lbl, ante, cons, msg)
`define CKAO_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ design/ckao_pkg.sv @@
// ---------------------------------------------------------------------------
// Chroma key alpha overlay package
// Item types, register map, configuration struct and stage payloads.
// ---------------------------------------------------------------------------
package ckao_pkg;

	localparam int MAX_DIM = 4096;

	// Full-scale effective alpha: 255 * 256.
	localparam logic [15:0] ALPHA_ONE   = 16'd65280;
	localparam logic [8:0]  OPACITY_MAX = 9'd256;
	localparam logic [12:0] DIM_LIMIT   = 13'(MAX_DIM);

	localparam int ADDR_W = 5;

	// Register indexes (word address).
	localparam logic [2:0] REG_OFFSET_X      = 3'd0;
	localparam logic [2:0] REG_OFFSET_Y      = 3'd1;
	localparam logic [2:0] REG_FRAME_WIDTH   = 3'd2;
	localparam logic [2:0] REG_FRAME_HEIGHT  = 3'd3;
	localparam logic [2:0] REG_OPACITY       = 3'd4;
	localparam logic [2:0] REG_KEY_ENABLE    = 3'd5;
	localparam logic [2:0] REG_KEY_COLOR     = 3'd6;
	localparam logic [2:0] REG_KEY_TOLERANCE = 3'd7;

	typedef struct packed {
		logic [11:0] fg_x;
		logic [11:0] fg_y;
		logic [7:0]  fg_blue;
		logic [7:0]  fg_green;
		logic [7:0]  fg_red;
		logic [7:0]  mask_alpha;
		logic [7:0]  bg_blue;
		logic [7:0]  bg_green;
		logic [7:0]  bg_red;
	} in_item_t;

	typedef struct packed {
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic [7:0]  out_blue;
		logic [7:0]  out_green;
		logic [7:0]  out_red;
		logic        write_flag;
	} out_item_t;

	typedef struct packed {
		logic signed [12:0] offset_x;
		logic signed [12:0] offset_y;
		logic [12:0]        frame_width;
		logic [12:0]        frame_height;
		logic [8:0]         opacity;
		logic               key_enable;
		logic [23:0]        key_color;
		logic [7:0]         key_tolerance;
	} cfg_t;

	// Channel index 0 blue, 1 green, 2 red.
	typedef logic [2:0][7:0] rgb_t;

	typedef struct packed {
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic        in_frame;
		logic [7:0]  m;
		rgb_t        fg;
		rgb_t        bg;
	} front_t;

	typedef struct packed {
		logic [11:0] dest_x;
		logic [11:0] dest_y;
		logic        flag;
		logic [15:0] a;
		rgb_t        fg;
		rgb_t        bg;
	} alpha_t;

	typedef struct packed {
		logic [11:0]      dest_x;
		logic [11:0]      dest_y;
		logic             flag;
		logic [2:0][23:0] num;
		rgb_t             bg;
	} mix_t;

	typedef struct packed {
		logic [11:0]      dest_x;
		logic [11:0]      dest_y;
		logic             flag;
		logic [2:0][15:0] q1;
		rgb_t             est;
		rgb_t             bg;
	} quot_t;

endpackage

@@ design/ckao_cfg.sv @@
// ---------------------------------------------------------------------------
// Chroma key alpha overlay register file
// APB-style register bank holding placement, clipping, opacity and key setup.
// ---------------------------------------------------------------------------
module ckao_cfg (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [ckao_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]               pwdata,
	output logic [31:0]               prdata,
	output logic                      pready,
	output ckao_pkg::cfg_t            cfg
);
	import ckao_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] idx;
	logic       wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.offset_x      <= '0;
			cfg_q.offset_y      <= '0;
			cfg_q.frame_width   <= 13'd1920;
			cfg_q.frame_height  <= 13'd1080;
			cfg_q.opacity       <= OPACITY_MAX;
			cfg_q.key_enable    <= 1'b0;
			cfg_q.key_color     <= 24'h00FF00;
			cfg_q.key_tolerance <= 8'd40;
		end else if (wr_en) begin
			unique case (idx)
				REG_OFFSET_X:      cfg_q.offset_x      <= pwdata[12:0];
				REG_OFFSET_Y:      cfg_q.offset_y      <= pwdata[12:0];
				REG_FRAME_WIDTH:   cfg_q.frame_width   <= pwdata[12:0];
				REG_FRAME_HEIGHT:  cfg_q.frame_height  <= pwdata[12:0];
				REG_OPACITY:       cfg_q.opacity       <= pwdata[8:0];
				REG_KEY_ENABLE:    cfg_q.key_enable    <= pwdata[0];
				REG_KEY_COLOR:     cfg_q.key_color     <= pwdata[23:0];
				REG_KEY_TOLERANCE: cfg_q.key_tolerance <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (idx)
			REG_OFFSET_X:      prdata = 32'(cfg_q.offset_x);
			REG_OFFSET_Y:      prdata = 32'(cfg_q.offset_y);
			REG_FRAME_WIDTH:   prdata = 32'(cfg_q.frame_width);
			REG_FRAME_HEIGHT:  prdata = 32'(cfg_q.frame_height);
			REG_OPACITY:       prdata = 32'(cfg_q.opacity);
			REG_KEY_ENABLE:    prdata = 32'(cfg_q.key_enable);
			REG_KEY_COLOR:     prdata = 32'(cfg_q.key_color);
			REG_KEY_TOLERANCE: prdata = 32'(cfg_q.key_tolerance);
			default:           prdata = '0;
		endcase
	end

endmodule

@@ design/ckao_front.sv @@
// ---------------------------------------------------------------------------
// Chroma key alpha overlay front stage
// Chroma key test and frame clipping, one pipeline stage.
// ---------------------------------------------------------------------------
module ckao_front (
	input  logic               clk,
	input  logic               arst_n,
	input  ckao_pkg::cfg_t     cfg,
	input  logic               in_valid,
	output logic               in_stall,
	input  ckao_pkg::in_item_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output ckao_pkg::front_t   out_data
);
	import ckao_pkg::*;

	logic        v_s1;
	front_t      d_s1;
	front_t      nxt;
	logic        rdy;
	rgb_t        fg;
	rgb_t        key;
	rgb_t        diff;
	logic [9:0]  key_dist;
	logic [9:0]  tol3;
	logic        keyed;
	logic [13:0] dx;
	logic [13:0] dy;
	logic [12:0] fw;
	logic [12:0] fh;

	assign rdy       = !v_s1 || !out_stall;
	assign in_stall  = !rdy;
	assign out_valid = v_s1;
	assign out_data  = d_s1;

	always_comb begin
		fg  = {in_item.fg_red, in_item.fg_green, in_item.fg_blue};
		key = cfg.key_color;
		for (int c = 0; c < 3; c++) begin
			diff[c] = (fg[c] > key[c]) ? fg[c] - key[c] : key[c] - fg[c];
		end
		key_dist = 10'(diff[0]) + 10'(diff[1]) + 10'(diff[2]);
		tol3     = 10'(cfg.key_tolerance) + {1'b0, cfg.key_tolerance, 1'b0};
		keyed    = cfg.key_enable && (key_dist < tol3);

		// Offsets are sign-extended; the sum never leaves 14 signed bits.
		dx = {cfg.offset_x[12], cfg.offset_x} + {2'b00, in_item.fg_x};
		dy = {cfg.offset_y[12], cfg.offset_y} + {2'b00, in_item.fg_y};
		fw = (cfg.frame_width  > DIM_LIMIT) ? DIM_LIMIT : cfg.frame_width;
		fh = (cfg.frame_height > DIM_LIMIT) ? DIM_LIMIT : cfg.frame_height;

		nxt.dest_x   = dx[11:0];
		nxt.dest_y   = dy[11:0];
		nxt.in_frame = !dx[13] && !dy[13] && (dx[12:0] < fw) && (dy[12:0] < fh);
		nxt.m        = keyed ? 8'd0 : in_item.mask_alpha;
		nxt.fg       = fg;
		nxt.bg       = {in_item.bg_red, in_item.bg_green, in_item.bg_blue};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy && in_valid) begin
			d_s1 <= nxt;
		end
	end

endmodule

@@ design/ckao_mix.sv @@
// ---------------------------------------------------------------------------
// Chroma key alpha overlay mixer
// Effective alpha in one stage, weighted channel sums in the next.
// ---------------------------------------------------------------------------
module ckao_mix (
	input  logic             clk,
	input  logic             arst_n,
	input  ckao_pkg::cfg_t   cfg,
	input  logic             in_valid,
	output logic             in_stall,
	input  ckao_pkg::front_t in_data,
	output logic             out_valid,
	input  logic             out_stall,
	output ckao_pkg::mix_t   out_data
);
	import ckao_pkg::*;

	logic        v_s2;
	logic        v_s3;
	alpha_t      d_s2;
	mix_t        d_s3;
	logic        rdy2;
	logic        rdy3;
	logic [8:0]  op;
	logic [16:0] prod;
	alpha_t      nxt2;
	mix_t        nxt3;
	logic [15:0] inv_a;

	assign rdy3      = !v_s3 || !out_stall;
	assign rdy2      = !v_s2 || rdy3;
	assign in_stall  = !rdy2;
	assign out_valid = v_s3;
	assign out_data  = d_s3;

	always_comb begin
		op   = (cfg.opacity > OPACITY_MAX) ? OPACITY_MAX : cfg.opacity;
		prod = 17'(in_data.m) * 17'(op);
		nxt2.dest_x = in_data.dest_x;
		nxt2.dest_y = in_data.dest_y;
		nxt2.a      = prod[15:0];
		nxt2.flag   = in_data.in_frame && (prod[15:0] != 16'd0);
		nxt2.fg     = in_data.fg;
		nxt2.bg     = in_data.bg;
	end

	always_comb begin
		inv_a = ALPHA_ONE - d_s2.a;
		nxt3.dest_x = d_s2.dest_x;
		nxt3.dest_y = d_s2.dest_y;
		nxt3.flag   = d_s2.flag;
		nxt3.bg     = d_s2.bg;
		for (int c = 0; c < 3; c++) begin
			nxt3.num[c] = 24'(d_s2.fg[c]) * 24'(d_s2.a) + 24'(d_s2.bg[c]) * 24'(inv_a);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy2) begin
				v_s2 <= in_valid;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && in_valid) begin
			d_s2 <= nxt2;
		end
		if (rdy3 && v_s2) begin
			d_s3 <= nxt3;
		end
	end

endmodule

@@ design/ckao_div.sv @@
// ---------------------------------------------------------------------------
// Chroma key alpha overlay divider
// Divides the weighted sums by 65280 through a reciprocal estimate and one
// correction step, then forms the result item.
// ---------------------------------------------------------------------------
module ckao_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  ckao_pkg::mix_t      in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output ckao_pkg::out_item_t out_item
);
	import ckao_pkg::*;

	logic      v_s4;
	logic      v_s5;
	quot_t     d_s4;
	out_item_t d_s5;
	logic      rdy4;
	logic      rdy5;
	quot_t     nxt4;
	out_item_t nxt5;
	logic [2:0][23:0] p;
	logic [2:0][16:0] r;
	rgb_t      q;

	assign rdy5      = !v_s5 || !out_stall;
	assign rdy4      = !v_s4 || rdy5;
	assign in_stall  = !rdy4;
	assign out_valid = v_s5;
	assign out_item  = d_s5;

	// n / 65280 = (n / 256) / 255. The estimate q1 * 257 / 65536 is at most
	// one below the true quotient.
	always_comb begin
		nxt4.dest_x = in_data.dest_x;
		nxt4.dest_y = in_data.dest_y;
		nxt4.flag   = in_data.flag;
		nxt4.bg     = in_data.bg;
		for (int c = 0; c < 3; c++) begin
			nxt4.q1[c]  = in_data.num[c][23:8];
			p[c]        = {8'd0, in_data.num[c][23:8]} + {in_data.num[c][23:8], 8'd0};
			nxt4.est[c] = p[c][23:16];
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			r[c] = 17'(d_s4.q1[c]) + 17'(d_s4.est[c]) - {1'b0, d_s4.est[c], 8'd0};
			q[c] = (r[c] >= 17'd255) ? d_s4.est[c] + 8'd1 : d_s4.est[c];
		end
		nxt5.write_flag = d_s4.flag;
		nxt5.dest_x     = d_s4.flag ? d_s4.dest_x : 12'd0;
		nxt5.dest_y     = d_s4.flag ? d_s4.dest_y : 12'd0;
		nxt5.out_blue   = d_s4.flag ? q[0] : d_s4.bg[0];
		nxt5.out_green  = d_s4.flag ? q[1] : d_s4.bg[1];
		nxt5.out_red    = d_s4.flag ? q[2] : d_s4.bg[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy4) begin
				v_s4 <= in_valid;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4 && in_valid) begin
			d_s4 <= nxt4;
		end
		if (rdy5 && v_s4) begin
			d_s5 <= nxt5;
		end
	end

endmodule

@@ design/chroma_key_alpha_overlay.sv @@
// ---------------------------------------------------------------------------
// Chroma key alpha overlay
// Per-pixel compositor: chroma key, clipping, alpha blend into background.
// ---------------------------------------------------------------------------
// Each input item carries one overlay pixel, its overlay coordinates, its
// mask alpha and the background pixel under it. Each item yields exactly one
// result item with the destination coordinates, the blended color and a
// write flag; with the flag clear the coordinates read zero and the color is
// the background color.
// Both channels use valid and stall. The pipeline has five register stages
// (key and clip, alpha product, channel products, quotient estimate,
// correction and output register); an accepted item passes through them in
// that order and stays in a stage while the next one is full and stalled.
// One item is accepted every cycle while out_stall is low.
// When the receiver stalls, items keep moving into empty stages, so in_stall
// rises only once all five stages hold an item.
// Reset clears all stage valid bits and loads the register defaults.
// Registers are written through the APB port at byte addresses 4 * index,
// by the user only while the pipeline is empty; the block does not check.
// ---------------------------------------------------------------------------
`include "chroma_key_alpha_overlay_defines.svh"

module chroma_key_alpha_overlay (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ckao_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  ckao_pkg::in_item_t          in_item,
	output logic                        out_valid,
	input  logic                        out_stall,
	output ckao_pkg::out_item_t         out_item
);
	import ckao_pkg::*;

	cfg_t   cfg;
	front_t front_data;
	mix_t   mix_data;
	logic   front_valid;
	logic   front_stall;
	logic   mix_valid;
	logic   mix_stall;

	ckao_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	ckao_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (front_valid),
		.out_stall (front_stall),
		.out_data  (front_data)
	);

	ckao_mix u_mix (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (front_valid),
		.in_stall  (front_stall),
		.in_data   (front_data),
		.out_valid (mix_valid),
		.out_stall (mix_stall),
		.out_data  (mix_data)
	);

	ckao_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (mix_valid),
		.in_stall  (mix_stall),
		.in_data   (mix_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

	// Back-pressure at the input can only come from a full, stalled output.
	`CKAO_ASSERT_IMPL(a_stall_source, in_stall, out_valid && out_stall, "input stall without stalled output")
	// A result with the flag clear carries zero coordinates.
	`CKAO_ASSERT_IMPL(a_clear_coords, out_valid && !out_item.write_flag, (out_item.dest_x == 12'd0) && (out_item.dest_y == 12'd0), "coordinates set on unwritten item")
	// With the receiver free, an accepted item reaches the output.
	`CKAO_ASSERT_NEXT(a_latency, (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall ##1 !out_stall, out_valid, "item did not reach output")

endmodule
